/* rtl/csm_pkg.sv */
// Shared types and constants of the CPU schedule metrics block.
// Used by csm_ctrl, csm_dp and cpu_schedule_metrics; no dependencies.
`default_nettype none
package csm_pkg;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SJF  = 2'd1,
    POL_PRIO = 2'd2,
    POL_RR   = 2'd3
  } policy_e;

  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  urgency;
    logic        last_proc;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  proc_number;
    logic [21:0] finish_time;
    logic [21:0] turnaround;
    logic [21:0] waiting;
    logic [26:0] total_waiting;
    logic [26:0] total_turnaround;
    logic        last_result;
  } out_word_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  urgency;
  } proc_ent_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SORT_RDI,
    CMD_SORT_LATI,
    CMD_SORT_RDJ,
    CMD_SORT_CMP,
    CMD_SORT_WR,
    CMD_PERM_RDO,
    CMD_PERM_RDP,
    CMD_PERM_WR,
    CMD_RR_INIT,
    CMD_RR_SETCLK,
    CMD_ADM_RD,
    CMD_ADM_PUSH,
    CMD_RR_JUMP,
    CMD_RR_POP,
    CMD_RR_RDREM,
    CMD_RR_SLICE,
    CMD_RR_FINISH,
    CMD_RR_REQUEUE,
    CMD_OUT_RD,
    CMD_OUT_EMIT
  } dp_cmd_e;

  typedef struct packed {
    logic batch_end;
    logic j_last;
    logic i_last;
    logic k_last;
    logic rr_mode;
    logic nxt_end;
    logic arr_le;
    logic done_all;
    logic q_empty;
    logic rem_zero;
    logic out_free;
  } dp_sts_t;

  function automatic logic [15:0] sort_key(policy_e pol, proc_ent_t e);
    logic [15:0] k;
    unique case (pol)
      POL_SJF:  k = e.burst;
      POL_PRIO: k = {8'd0, e.urgency};
      default:  k = e.arrival;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* rtl/csm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module csm_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic                 re_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* rtl/csm_ctrl.sv */
// Sequencer of the schedule metrics block: load, sort, permute, round robin
// simulation and result phases. Depends on csm_pkg.
`default_nettype none
module csm_ctrl import csm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire dp_sts_t sts_i,
  output dp_cmd_e      cmd_o
);
  typedef enum logic [18:0] {
    ST_LOAD  = 19'd1,
    ST_SRDI  = 19'd2,
    ST_SLAT  = 19'd4,
    ST_SRDJ  = 19'd8,
    ST_SCMP  = 19'd16,
    ST_SWR   = 19'd32,
    ST_PRDO  = 19'd64,
    ST_PRDP  = 19'd128,
    ST_PWR   = 19'd256,
    ST_RINIT = 19'd512,
    ST_RCLK  = 19'd1024,
    ST_ARD   = 19'd2048,
    ST_ACHK  = 19'd4096,
    ST_LOOP  = 19'd8192,
    ST_POP   = 19'd16384,
    ST_SLICE = 19'd32768,
    ST_POST  = 19'd65536,
    ST_ORD   = 19'd131072,
    ST_OEMIT = 19'd262144
  } state_e;

  state_e state_q, state_d;
  logic   ret_post_q, ret_post_d;
  state_e ret_st;

  assign ret_st = ret_post_q ? ST_POST : ST_LOOP;

  always_comb begin
    state_d    = state_q;
    ret_post_d = ret_post_q;
    cmd_o      = CMD_NONE;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o = CMD_LOAD;
        if (sts_i.batch_end) state_d = ST_SRDI;
      end
      ST_SRDI: begin
        cmd_o   = CMD_SORT_RDI;
        state_d = ST_SLAT;
      end
      ST_SLAT: begin
        cmd_o   = CMD_SORT_LATI;
        state_d = ST_SRDJ;
      end
      ST_SRDJ: begin
        cmd_o   = CMD_SORT_RDJ;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        cmd_o   = CMD_SORT_CMP;
        state_d = sts_i.j_last ? ST_SWR : ST_SRDJ;
      end
      ST_SWR: begin
        cmd_o   = CMD_SORT_WR;
        state_d = sts_i.i_last ? ST_PRDO : ST_SRDI;
      end
      ST_PRDO: begin
        cmd_o   = CMD_PERM_RDO;
        state_d = ST_PRDP;
      end
      ST_PRDP: begin
        cmd_o   = CMD_PERM_RDP;
        state_d = ST_PWR;
      end
      ST_PWR: begin
        cmd_o = CMD_PERM_WR;
        if (!sts_i.k_last)       state_d = ST_PRDO;
        else if (sts_i.rr_mode)  state_d = ST_RINIT;
        else                     state_d = ST_ORD;
      end
      ST_RINIT: begin
        cmd_o   = CMD_RR_INIT;
        state_d = ST_RCLK;
      end
      ST_RCLK: begin
        cmd_o      = CMD_RR_SETCLK;
        ret_post_d = 1'b0;
        state_d    = ST_ARD;
      end
      ST_ARD: begin
        if (sts_i.nxt_end) begin
          state_d = ret_st;
        end else begin
          cmd_o   = CMD_ADM_RD;
          state_d = ST_ACHK;
        end
      end
      ST_ACHK: begin
        if (sts_i.arr_le) begin
          cmd_o   = CMD_ADM_PUSH;
          state_d = ST_ARD;
        end else begin
          state_d = ret_st;
        end
      end
      ST_LOOP: begin
        priority if (sts_i.done_all) begin
          state_d = ST_ORD;
        end else if (sts_i.q_empty) begin
          if (sts_i.nxt_end) begin
            state_d = ST_ORD;
          end else begin
            cmd_o   = CMD_RR_JUMP;
            state_d = ST_RCLK;
          end
        end else begin
          cmd_o   = CMD_RR_POP;
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o   = CMD_RR_RDREM;
        state_d = ST_SLICE;
      end
      ST_SLICE: begin
        cmd_o      = CMD_RR_SLICE;
        ret_post_d = 1'b1;
        state_d    = ST_ARD;
      end
      ST_POST: begin
        cmd_o   = sts_i.rem_zero ? CMD_RR_FINISH : CMD_RR_REQUEUE;
        state_d = ST_LOOP;
      end
      ST_ORD: begin
        cmd_o   = CMD_OUT_RD;
        state_d = ST_OEMIT;
      end
      ST_OEMIT: begin
        if (sts_i.out_free) begin
          cmd_o   = CMD_OUT_EMIT;
          state_d = sts_i.k_last ? ST_LOAD : ST_ORD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      ret_post_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_post_q <= ret_post_d;
    end
  end
endmodule
`default_nettype wire

/* rtl/csm_dp.sv */
// Datapath of the schedule metrics block: process stores, rank sort,
// ready queue, schedule clock and result register. Depends on csm_pkg, csm_ram.
`default_nettype none
module csm_dp import csm_pkg::*; #(
  parameter int MAX_PROCS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_e     cmd_i,
  output dp_sts_t          sts_o,
  input  wire policy_e     policy_i,
  input  wire logic [15:0] quantum_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o
);
  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_PROCS);
  localparam logic [AW-1:0] LastIdx = AW'(MAX_PROCS - 1);

  typedef struct packed {
    logic [AW-1:0] id;
    logic [15:0]   arrival;
    logic [15:0]   burst;
  } srt_ent_t;

  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, nxt_q, nxt_d, done_q, done_d, fill_q, fill_d;
  logic [AW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, rank_q, rank_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d, kcur_q, kcur_d;
  logic [15:0]   keyi_q, keyi_d;
  logic [21:0]   clock_q, clock_d;
  logic          remz_q, remz_d;
  logic [26:0]   totw_q, totw_d, tott_q, tott_d;
  logic          ovld_q, ovld_d;
  out_word_t     out_q, out_d;

  // RAM ports
  logic          p_we, p_re, o_we, o_re, s_we, s_re, r_we, r_re, f_we, f_re, q_we, q_re;
  logic [AW-1:0] p_ra, o_wa, s_ra, r_wa, r_ra, f_wa, q_wa;
  proc_ent_t     p_rd;
  logic [AW-1:0] o_rd, q_rd, q_wd;
  srt_ent_t      s_rd, s_wd;
  logic [15:0]   r_rd, r_wd;
  logic [21:0]   f_rd, f_wd;

  logic          accept, store, use_arr;
  logic [CW-1:0] cnt_inc, n_m1;
  logic [15:0]   keyj, q_eff, slice, rem_new;
  logic [21:0]   arr_eff, tat, wt, burst_x;

  assign accept   = (cmd_i == CMD_LOAD) && in_valid_i;
  assign store    = accept && (cnt_q < MaxCnt);
  assign cnt_inc  = cnt_q + CW'(store);
  assign n_m1     = n_q - CW'(1);
  assign use_arr  = (policy_i == POL_FCFS) || (policy_i == POL_RR);
  assign q_eff    = (quantum_i == 16'd0) ? 16'd1 : quantum_i;
  assign keyj     = sort_key(policy_i, p_rd);
  assign slice    = (r_rd < q_eff) ? r_rd : q_eff;
  assign rem_new  = r_rd - slice;
  assign arr_eff  = use_arr ? {6'd0, s_rd.arrival} : 22'd0;
  assign burst_x  = {6'd0, s_rd.burst};
  assign tat      = (f_rd >= arr_eff) ? f_rd - arr_eff : 22'd0;
  assign wt       = (tat >= burst_x) ? tat - burst_x : 22'd0;

  // Permute step forms its write word from the process store read.
  always_comb begin
    s_wd.id      = o_rd;
    s_wd.arrival = p_rd.arrival;
    s_wd.burst   = p_rd.burst;
  end

  assign in_stall_o  = (cmd_i != CMD_LOAD);
  assign out_valid_o = ovld_q;
  assign out_word_o  = out_q;

  always_comb begin
    sts_o.batch_end = accept && in_word_i.last_proc;
    sts_o.j_last    = (CW'(j_q) == n_m1);
    sts_o.i_last    = (CW'(i_q) == n_m1);
    sts_o.k_last    = (CW'(k_q) == n_m1);
    sts_o.rr_mode   = (policy_i == POL_RR);
    sts_o.nxt_end   = (nxt_q >= n_q);
    sts_o.arr_le    = ({6'd0, s_rd.arrival} <= clock_q);
    sts_o.done_all  = (done_q == n_q);
    sts_o.q_empty   = (fill_q == '0);
    sts_o.rem_zero  = remz_q;
    sts_o.out_free  = !ovld_q || !out_stall_i;
  end

  always_comb begin
    cnt_d = cnt_q;  n_d = n_q;  nxt_d = nxt_q;  done_d = done_q;  fill_d = fill_q;
    i_d = i_q;  j_d = j_q;  k_d = k_q;  rank_d = rank_q;
    head_d = head_q;  tail_d = tail_q;  kcur_d = kcur_q;  keyi_d = keyi_q;
    clock_d = clock_q;  remz_d = remz_q;  totw_d = totw_q;  tott_d = tott_q;
    out_d = out_q;
    ovld_d = ovld_q && out_stall_i;
    p_we = 1'b0;  p_re = 1'b0;  p_ra = i_q;
    o_we = 1'b0;  o_re = 1'b0;  o_wa = rank_q;
    s_we = 1'b0;  s_re = 1'b0;  s_ra = k_q;
    r_we = 1'b0;  r_re = 1'b0;  r_wa = k_q;  r_wd = p_rd.burst;  r_ra = q_rd;
    f_we = 1'b0;  f_re = 1'b0;  f_wa = k_q;  f_wd = clock_q;
    q_we = 1'b0;  q_re = 1'b0;  q_wa = tail_q;  q_wd = nxt_q[AW-1:0];
    unique case (cmd_i)
      CMD_LOAD: begin
        p_we = store;
        if (accept) begin
          if (in_word_i.last_proc) begin
            n_d   = cnt_inc;
            cnt_d = '0;
            i_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      CMD_SORT_RDI: begin
        p_re = 1'b1;  p_ra = i_q;
        j_d = '0;  rank_d = '0;
      end
      CMD_SORT_LATI: keyi_d = keyj;
      CMD_SORT_RDJ: begin
        p_re = 1'b1;  p_ra = j_q;
      end
      CMD_SORT_CMP: begin
        // stable rank: smaller keys, and equal keys loaded earlier
        if ((keyj < keyi_q) || ((keyj == keyi_q) && (j_q < i_q))) rank_d = rank_q + AW'(1);
        j_d = j_q + AW'(1);
      end
      CMD_SORT_WR: begin
        o_we = 1'b1;
        i_d = i_q + AW'(1);
        k_d = '0;  clock_d = '0;  totw_d = '0;  tott_d = '0;
      end
      CMD_PERM_RDO: begin
        o_re = 1'b1;
      end
      CMD_PERM_RDP: begin
        p_re = 1'b1;  p_ra = o_rd;
      end
      CMD_PERM_WR: begin
        s_we = 1'b1;
        r_we = 1'b1;
        if (policy_i != POL_RR) begin
          // with the sorted entry not yet readable, take times from the process store
          f_we = 1'b1;
        end
        k_d = sts_o.k_last ? '0 : k_q + AW'(1);
      end
      CMD_RR_INIT: begin
        s_re = 1'b1;  s_ra = '0;
        nxt_d = '0;  done_d = '0;  head_d = '0;  tail_d = '0;  fill_d = '0;
      end
      CMD_RR_SETCLK: clock_d = {6'd0, s_rd.arrival};
      CMD_ADM_RD, CMD_RR_JUMP: begin
        s_re = 1'b1;  s_ra = nxt_q[AW-1:0];
      end
      CMD_ADM_PUSH: begin
        q_we   = 1'b1;
        tail_d = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
        fill_d = fill_q + CW'(1);
        nxt_d  = nxt_q + CW'(1);
      end
      CMD_RR_POP: begin
        q_re   = 1'b1;
        head_d = (head_q == LastIdx) ? '0 : head_q + AW'(1);
        fill_d = fill_q - CW'(1);
      end
      CMD_RR_RDREM: begin
        r_re = 1'b1;  r_ra = q_rd;
        kcur_d = q_rd;
      end
      CMD_RR_SLICE: begin
        clock_d = clock_q + {6'd0, slice};
        r_we = 1'b1;  r_wa = kcur_q;  r_wd = rem_new;
        remz_d = (rem_new == 16'd0);
      end
      CMD_RR_FINISH: begin
        f_we = 1'b1;  f_wa = kcur_q;  f_wd = clock_q;
        done_d = done_q + CW'(1);
      end
      CMD_RR_REQUEUE: begin
        q_we   = 1'b1;  q_wd = kcur_q;
        tail_d = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
        fill_d = fill_q + CW'(1);
      end
      CMD_OUT_RD: begin
        s_re = 1'b1;  f_re = 1'b1;
      end
      CMD_OUT_EMIT: begin
        totw_d = totw_q + {5'd0, wt};
        tott_d = tott_q + {5'd0, tat};
        out_d.proc_number      = 6'(s_rd.id) + 6'd1;
        out_d.finish_time      = f_rd;
        out_d.turnaround       = tat;
        out_d.waiting          = wt;
        out_d.last_result      = sts_o.k_last;
        out_d.total_waiting    = sts_o.k_last ? totw_d : 27'd0;
        out_d.total_turnaround = sts_o.k_last ? tott_d : 27'd0;
        ovld_d = 1'b1;
        k_d = k_q + AW'(1);
      end
      default: ;
    endcase
  end

  // The permute write uses the process store for clock update, not the sorted store.
  logic [21:0] perm_arr, perm_base, perm_clk;
  assign perm_arr  = use_arr ? {6'd0, p_rd.arrival} : 22'd0;
  assign perm_base = (perm_arr > clock_q) ? perm_arr : clock_q;
  assign perm_clk  = perm_base + {6'd0, p_rd.burst};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;  n_q  <= '0;  nxt_q <= '0;  done_q <= '0;  fill_q <= '0;
      i_q    <= '0;  j_q  <= '0;  k_q   <= '0;  rank_q <= '0;
      head_q <= '0;  tail_q <= '0;  kcur_q <= '0;
      clock_q <= '0;  remz_q <= 1'b0;  totw_q <= '0;  tott_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;  n_q  <= n_d;  nxt_q <= nxt_d;  done_q <= done_d;  fill_q <= fill_d;
      i_q    <= i_d;  j_q  <= j_d;  k_q   <= k_d;  rank_q <= rank_d;
      head_q <= head_d;  tail_q <= tail_d;  kcur_q <= kcur_d;
      clock_q <= (cmd_i == CMD_PERM_WR && policy_i != POL_RR) ? perm_clk : clock_d;
      remz_q <= remz_d;  totw_q <= totw_d;  tott_q <= tott_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    keyi_q <= keyi_d;
    out_q  <= out_d;
  end

  csm_ram #(.W($bits(proc_ent_t)), .D(MAX_PROCS)) u_proc_ram (
    .clk_i, .we_i(p_we), .waddr_i(cnt_q[AW-1:0]),
    .wdata_i({in_word_i.arrival, in_word_i.burst, in_word_i.urgency}),
    .re_i(p_re), .raddr_i(p_ra), .rdata_o(p_rd)
  );

  csm_ram #(.W(AW), .D(MAX_PROCS)) u_order_ram (
    .clk_i, .we_i(o_we), .waddr_i(o_wa), .wdata_i(i_q),
    .re_i(o_re), .raddr_i(k_q), .rdata_o(o_rd)
  );

  csm_ram #(.W($bits(srt_ent_t)), .D(MAX_PROCS)) u_sorted_ram (
    .clk_i, .we_i(s_we), .waddr_i(k_q), .wdata_i(s_wd),
    .re_i(s_re), .raddr_i(s_ra), .rdata_o(s_rd)
  );

  csm_ram #(.W(16), .D(MAX_PROCS)) u_rem_ram (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd),
    .re_i(r_re), .raddr_i(r_ra), .rdata_o(r_rd)
  );

  csm_ram #(.W(22), .D(MAX_PROCS)) u_fin_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_wa),
    .wdata_i((cmd_i == CMD_PERM_WR) ? perm_clk : f_wd),
    .re_i(f_re), .raddr_i(k_q), .rdata_o(f_rd)
  );

  csm_ram #(.W(AW), .D(MAX_PROCS)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd),
    .re_i(q_re), .raddr_i(head_q), .rdata_o(q_rd)
  );
endmodule
`default_nettype wire

/* rtl/cpu_schedule_metrics.sv */
// Top level of the CPU schedule metrics block: configuration registers,
// sequencer and datapath. Depends on csm_pkg, csm_ctrl, csm_dp, csm_ram.
//
// Processes are loaded one word per cycle while in the load phase; the word
// flagged last_proc closes the batch (words past MAX_PROCS are dropped, their
// flag still counts). The batch of n processes is then stable-sorted by the
// policy key with a rank count that reads the process store once per pair,
// permuted into sorted order, and for round robin simulated slice by slice.
// Results follow in sorted order through one output register; the last
// carries the batch totals. Every store access goes through a one-read,
// one-write RAM with registered read, so each read and the use of its data
// are separate steps.
// Input is stalled from the closing word until the last result is registered.
`default_nettype none
module cpu_schedule_metrics import csm_pkg::*; #(
  parameter int MAX_PROCS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o
);
  policy_e     policy_q;
  logic [15:0] quantum_q;
  dp_cmd_e     cmd;
  dp_sts_t     sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_FCFS;
      quantum_q <= 16'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLICY:  policy_q  <= policy_e'(cfg_wdata_i[1:0]);
        REG_QUANTUM: quantum_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  csm_ctrl u_ctrl (
    .clk_i, .rst_ni, .sts_i(sts), .cmd_o(cmd)
  );

  csm_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .policy_i(policy_q), .quantum_i(quantum_q),
    .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  a_load_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (cmd == CMD_LOAD))
    else $error("input word taken outside load phase");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_RR_POP) |-> !sts.q_empty)
    else $error("ready queue popped while empty");

  a_totals_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.last_result) |->
      (out_word_o.total_waiting == 27'd0 && out_word_o.total_turnaround == 27'd0))
    else $error("totals on a result that is not the last");
endmodule
`default_nettype wire

/* sim/csm_checker.sv */
// Scoreboard for cpu_schedule_metrics: follows the config port, predicts every
// batch schedule from the loaded processes and checks each result word.
// Depends on csm_pkg for the word types and policy codes.
module csm_checker import csm_pkg::*; #(
  parameter int MAX_PROCS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  policy_e     sched_pol;
  logic [15:0] slice_len;
  logic [15:0] arr_tbl [MAX_PROCS];
  logic [15:0] burst_tbl [MAX_PROCS];
  logic [7:0]  urg_tbl [MAX_PROCS];
  int          loaded;
  out_word_t   sched_q[$];

  function automatic int order_key(int id);
    if (sched_pol == POL_SJF) return burst_tbl[id];
    if (sched_pol == POL_PRIO) return urg_tbl[id];
    return arr_tbl[id];
  endfunction

  // Build the schedule of the loaded batch and queue one word per process.
  function automatic void schedule_batch();
    int        n, i, k, id, cur, q, nxt, done, now, slice, a, tat, wt;
    int        ord[MAX_PROCS];
    int        left[MAX_PROCS];
    int        fin[MAX_PROCS];
    int        ready[$];
    int        sum_w, sum_t;
    bit        by_arrival;
    out_word_t w;
    n = loaded;
    for (i = 0; i < n; i++) begin
      k = i;
      while (k > 0 && order_key(ord[k - 1]) > order_key(i)) begin
        ord[k] = ord[k - 1];
        k--;
      end
      ord[k] = i;
    end
    by_arrival = (sched_pol == POL_FCFS) || (sched_pol == POL_RR);
    if (sched_pol == POL_RR) begin
      q = (slice_len == 0) ? 1 : slice_len;
      for (i = 0; i < n; i++) left[i] = burst_tbl[i];
      now = arr_tbl[ord[0]];
      nxt = 0;
      done = 0;
      while (done < n) begin
        while (nxt < n && arr_tbl[ord[nxt]] <= now) begin
          ready.push_back(nxt);
          nxt++;
        end
        if (ready.size() == 0) begin
          if (nxt >= n) break;
          // queue idle: jump to the next arrival
          now = arr_tbl[ord[nxt]];
          continue;
        end
        cur = ready.pop_front();
        id = ord[cur];
        slice = (left[id] < q) ? left[id] : q;
        now += slice;
        left[id] -= slice;
        // admit arrivals before the preempted process goes back in line
        while (nxt < n && arr_tbl[ord[nxt]] <= now) begin
          ready.push_back(nxt);
          nxt++;
        end
        if (left[id] != 0) ready.push_back(cur);
        else begin
          fin[id] = now;
          done++;
        end
      end
    end else begin
      now = by_arrival ? arr_tbl[ord[0]] : 0;
      for (k = 0; k < n; k++) begin
        id = ord[k];
        if (by_arrival && arr_tbl[id] > now) now = arr_tbl[id];
        now += burst_tbl[id];
        fin[id] = now;
      end
    end
    sum_w = 0;
    sum_t = 0;
    for (k = 0; k < n; k++) begin
      id = ord[k];
      a = by_arrival ? arr_tbl[id] : 0;
      tat = (fin[id] >= a) ? fin[id] - a : 0;
      wt = (tat >= burst_tbl[id]) ? tat - burst_tbl[id] : 0;
      sum_w += wt;
      sum_t += tat;
      w = '0;
      w.proc_number = id + 1;
      w.finish_time = fin[id];
      w.turnaround = tat;
      w.waiting = wt;
      if (k == n - 1) begin
        w.total_waiting = sum_w;
        w.total_turnaround = sum_t;
        w.last_result = 1'b1;
      end
      sched_q.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      sched_pol = POL_FCFS;
      slice_len = 16'd4;
      loaded = 0;
      errors_o = 0;
      sched_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_POLICY) sched_pol = policy_e'(cfg_wdata_i[1:0]);
        else slice_len = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (sched_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result word %p", out_word_i);
        end else begin
          want = sched_q.pop_front();
          if (want.proc_number !== out_word_i.proc_number ||
              want.finish_time !== out_word_i.finish_time ||
              want.turnaround !== out_word_i.turnaround ||
              want.waiting !== out_word_i.waiting ||
              want.total_waiting !== out_word_i.total_waiting ||
              want.total_turnaround !== out_word_i.total_turnaround ||
              want.last_result !== out_word_i.last_result) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch at %0t: expected %p, got %p", $realtime, want, out_word_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // words past capacity are dropped, their flag still closes the batch
        if (loaded < MAX_PROCS) begin
          arr_tbl[loaded] = in_word_i.arrival;
          burst_tbl[loaded] = in_word_i.burst;
          urg_tbl[loaded] = in_word_i.urgency;
          loaded++;
        end
        if (in_word_i.last_proc) begin
          schedule_batch();
          loaded = 0;
        end
      end
    end
    pending_o = sched_q.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for cpu_schedule_metrics: clock, reset, process stimulus,
// output stall patterns and verdict. Depends on csm_pkg and csm_checker.
module tb;
  import csm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int ITEM_TARGET = 250;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  int          errors;
  int          pending;

  policy_e     cur_pol = POL_FCFS;
  logic [15:0] cur_slice = 16'd4;
  int          burst_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_cnt = 0;
  int          stall_mode = 0;
  int          stall_cyc = 0;
  int          idle_cyc = 0;

  always #5 clk_i = ~clk_i;

  cpu_schedule_metrics u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word)
  );

  csm_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_word_i(out_word),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver: one long hold-off on request, otherwise a drifting stall mix.
  // The hold outlasts sorting and scheduling of a full batch.
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 97 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 5000;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("cpu_schedule_metrics verification failed");
        $finish;
      end
    end
  end

  function automatic in_word_t proc_word(int arr, int bur, int urg, bit last);
    in_word_t w;
    w.arrival = arr;
    w.burst = bur;
    w.urgency = urg;
    w.last_proc = last;
    return w;
  endfunction

  function automatic in_word_t random_proc(bit last);
    int arr, bur, lim, q;
    case ($urandom_range(0, 2))
      0: arr = $urandom_range(0, 65535);
      1: arr = $urandom_range(0, 40);
      default: arr = $urandom_range(65500, 65535);
    endcase
    if (cur_pol == POL_RR) begin
      // keep slice counts bounded
      q = (cur_slice == 0) ? 1 : cur_slice;
      lim = (q * 6 > 65535) ? 65535 : q * 6;
      bur = $urandom_range(0, lim);
    end else begin
      case ($urandom_range(0, 2))
        0: bur = $urandom_range(0, 65535);
        1: bur = $urandom_range(0, 20);
        default: bur = 0;
      endcase
    end
    return proc_word(arr, bur, $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 3), last);
  endfunction

  // Offer one word, hold it until accepted, then maybe leave a gap.
  task automatic send_proc(in_word_t w);
    int gap;
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    gap = 0;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
    end
    // drop valid after a closing word
    if (w.last_proc && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(policy_e pol, logic [15:0] q);
    drain();
    write_reg(REG_POLICY, pol);
    write_reg(REG_QUANTUM, q);
    cur_pol = pol;
    cur_slice = q;
  endtask

  initial begin
    int sent, n, b;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // arrival order with field extremes, then a single-process batch
    send_proc(proc_word(0, 0, 0, 0));
    send_proc(proc_word(65535, 65535, 255, 0));
    send_proc(proc_word(100, 5, 7, 1));
    send_proc(proc_word(65535, 65535, 255, 1));
    // shortest job with a tie that must stay in input order
    set_mode(POL_SJF, 16'd4);
    send_proc(proc_word(10, 7, 3, 0));
    send_proc(proc_word(0, 7, 1, 0));
    send_proc(proc_word(5, 2, 9, 1));
    set_mode(POL_PRIO, 16'd4);
    send_proc(proc_word(1, 3, 200, 0));
    send_proc(proc_word(2, 4, 200, 0));
    send_proc(proc_word(3, 0, 0, 1));
    // round robin: zero slice acts as one, zero burst, idle jump
    set_mode(POL_RR, 16'd0);
    send_proc(proc_word(0, 3, 0, 0));
    send_proc(proc_word(1, 0, 0, 0));
    send_proc(proc_word(500, 2, 0, 1));
    set_mode(POL_RR, 16'd65535);
    send_proc(proc_word(0, 65535, 0, 0));
    send_proc(proc_word(65535, 65535, 255, 1));

    sent = 0;
    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: set_mode(policy_e'($urandom_range(0, 3)), 16'd1);
        1: set_mode(policy_e'($urandom_range(0, 3)), 16'd65535);
        2: set_mode(policy_e'($urandom_range(0, 3)), $urandom_range(1, 16));
        default: set_mode(policy_e'($urandom_range(0, 3)), $urandom_range(1, 65535));
      endcase
      for (b = $urandom_range(2, 4); b > 0; b--) begin
        if (!hold_done && sent > 40 && b > 1) begin
          // full batch against a blocked receiver, with another batch behind it
          hold_req <= 1'b1;
          n = 32;
        end else if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 1) ? 32 : 35;
        else n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_proc(random_proc(i == n - 1));
        sent += (n > 32) ? 32 : n;
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("cpu_schedule_metrics verification clean");
    else $display("cpu_schedule_metrics verification failed");
    $finish;
  end

endmodule
